FILE: rtl/lsos_pkg.sv
// ----------------------------------------------------------------------------
// lsos_pkg
// Shared types and constants for the laser sector obstacle steering block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsos_pkg;

  // configuration port geometry
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int SpsW     = 9;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLES_PER_SECTOR = 3'd0,
    CFG_STOP_DISTANCE      = 3'd1,
    CFG_TURN_DISTANCE      = 3'd2,
    CFG_TURN_GAIN          = 3'd3,
    CFG_IDLE_TURN          = 3'd4
  } cfg_idx_e;

  // request function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_SPEED  = 1'b1;

  // result kind codes
  localparam logic KIND_DRIVE = 1'b0;
  localparam logic KIND_SPEED = 1'b1;

  // sector indexes, right to left
  localparam logic [2:0] SEC_RIGHT   = 3'd0;
  localparam logic [2:0] SEC_FRIGHT  = 3'd1;
  localparam logic [2:0] SEC_FRONT   = 3'd2;
  localparam logic [2:0] SEC_FLEFT   = 3'd3;
  localparam logic [2:0] SEC_LEFT    = 3'd4;
  localparam logic [2:0] NUM_SECTORS = 3'd5;

  // reset values and fixed-point constants (Q8.8)
  localparam logic [SpsW-1:0]     SPS_RESET       = 9'd144;
  localparam logic [15:0]         STOP_RESET      = 16'd256;
  localparam logic [15:0]         TURN_DIST_RESET = 16'd512;
  localparam logic [15:0]         TURN_GAIN_RESET = 16'd512;
  localparam logic signed [15:0]  IDLE_TURN_RESET = 16'sd77;
  localparam logic [15:0]         SPEED_RESET     = 16'd256;
  localparam logic [15:0]         RANGE_MAX       = 16'hFFFF;
  localparam logic [8:0]          Q_ONE           = 9'd256;

  // snapshot of one finished scan, or a speed reply, headed for the command stages
  typedef struct packed {
    logic        kind;
    logic [15:0] speed;
    logic [15:0] min_right;
    logic [15:0] min_fright;
    logic [15:0] min_front;
    logic [15:0] min_fleft;
    logic [15:0] min_left;
  } cmd_req_t;

  // one result item
  typedef struct packed {
    logic               kind;
    logic [15:0]        linear;
    logic signed [15:0] angular;
    logic [15:0]        speed;
  } cmd_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/lsos_if.sv
// ----------------------------------------------------------------------------
// lsos_if
// Valid/ready channels for sample requests and steering results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lsos_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [15:0]        range_value;
  logic signed [15:0] speed_step;
  logic               last_of_scan;

  modport source (
    output valid, func, range_value, speed_step, last_of_scan,
    input  ready
  );
  modport sink (
    input  valid, func, range_value, speed_step, last_of_scan,
    output ready
  );
endinterface

interface lsos_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [15:0]        linear_cmd;
  logic signed [15:0] angular_cmd;
  logic [15:0]        speed_now;

  modport source (
    output valid, kind, linear_cmd, angular_cmd, speed_now,
    input  ready
  );
  modport sink (
    input  valid, kind, linear_cmd, angular_cmd, speed_now,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/lsos_cmd.sv
// ----------------------------------------------------------------------------
// lsos_cmd
// Two-stage drive command datapath: products, then weight sum, saturation and idle turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsos_cmd (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [15:0]              stop_distance_i,
  input  logic [15:0]              turn_distance_i,
  input  logic [15:0]              turn_gain_i,
  input  logic signed [15:0]       idle_turn_i,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  lsos_pkg::cmd_req_t       req_i,
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  output lsos_pkg::cmd_rsp_t       rsp_o
);
  import lsos_pkg::*;

  // turning weight of one side sector, Q16.8
  function automatic logic [23:0] side_weight(input logic [15:0] side_range,
                                              input logic [15:0] tdist,
                                              input logic [15:0] gain);
    logic [15:0] gap;
    logic [31:0] prod;
    gap  = tdist - side_range;
    prod = 32'(gap) * 32'(gain);
    if (side_range >= tdist) begin
      return 24'd0;
    end
    return prod[31:8];
  endfunction

  logic        ready2;
  logic        ready3;

  logic        vld2_q;
  logic        kind2_q;
  logic [15:0] lin2_q;
  logic [15:0] spd2_q;
  logic [23:0] w_right2_q, w_fright2_q, w_fleft2_q, w_left2_q;

  logic        kind2_d;
  logic [15:0] lin2_d;
  logic [23:0] w_right2_d, w_fright2_d, w_fleft2_d, w_left2_d;
  logic [8:0]  diff;
  logic [24:0] lin_prod;
  logic [15:0] front_gap;

  logic               vld3_q;
  cmd_rsp_t           rsp3_q;
  cmd_rsp_t           rsp3_d;
  logic signed [25:0] ang_sum;
  logic signed [15:0] ang_sat;

  // stall chain
  assign ready3      = !vld3_q || rsp_ready_i;
  assign ready2      = !vld2_q || ready3;
  assign req_ready_o = ready2;

  // stage 2: linear product and side weights
  always_comb begin
    front_gap = req_i.min_front - stop_distance_i;
    diff      = 9'd0;
    if (req_i.min_front > stop_distance_i) begin
      diff = (front_gap > 16'(Q_ONE)) ? Q_ONE : front_gap[8:0];
    end
    lin_prod    = 25'(diff) * 25'(req_i.speed);
    kind2_d     = req_i.kind;
    lin2_d      = lin_prod[23:8];
    w_right2_d  = side_weight(req_i.min_right, turn_distance_i, turn_gain_i);
    w_fright2_d = side_weight(req_i.min_fright, turn_distance_i, turn_gain_i);
    w_fleft2_d  = side_weight(req_i.min_fleft, turn_distance_i, turn_gain_i);
    w_left2_d   = side_weight(req_i.min_left, turn_distance_i, turn_gain_i);
    if (req_i.kind == KIND_SPEED) begin
      lin2_d      = 16'd0;
      w_right2_d  = 24'd0;
      w_fright2_d = 24'd0;
      w_fleft2_d  = 24'd0;
      w_left2_d   = 24'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (ready2) begin
      vld2_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && req_valid_i) begin
      kind2_q     <= kind2_d;
      lin2_q      <= lin2_d;
      spd2_q      <= req_i.speed;
      w_right2_q  <= w_right2_d;
      w_fright2_q <= w_fright2_d;
      w_fleft2_q  <= w_fleft2_d;
      w_left2_q   <= w_left2_d;
    end
  end

  // stage 3: weight sum, saturation and idle turn
  always_comb begin
    ang_sum = $signed({2'b00, w_right2_q}) + $signed({2'b00, w_fright2_q})
            - $signed({2'b00, w_fleft2_q}) - $signed({2'b00, w_left2_q});
    if (ang_sum > 26'sd32767) begin
      ang_sat = 16'sd32767;
    end else if (ang_sum < -26'sd32768) begin
      ang_sat = -16'sd32768;
    end else begin
      ang_sat = ang_sum[15:0];
    end
    rsp3_d.kind    = kind2_q;
    rsp3_d.linear  = lin2_q;
    rsp3_d.speed   = spd2_q;
    rsp3_d.angular = ang_sat;
    if (kind2_q == KIND_SPEED) begin
      rsp3_d.angular = 16'sd0;
    end else if (lin2_q == 16'd0 && ang_sat == 16'sd0) begin
      rsp3_d.angular = idle_turn_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (ready3) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && vld2_q) begin
      rsp3_q <= rsp3_d;
    end
  end

  assign rsp_valid_o = vld3_q;
  assign rsp_o       = rsp3_q;

`ifndef SYNTHESIS
  // a speed reply carries no motion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld3_q && rsp3_q.kind == KIND_SPEED) |-> (rsp3_q.linear == 16'd0 &&
                                               rsp3_q.angular == 16'sd0))
    else $error("speed reply with nonzero motion");

  // a drive command is only issued at nonzero speed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld3_q && rsp3_q.kind == KIND_DRIVE) |-> (rsp3_q.speed != 16'd0))
    else $error("drive command at zero speed");

  // a speed reply entering stage 2 reaches it with zero linear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld2_q && kind2_q == KIND_SPEED) |-> (lin2_q == 16'd0))
    else $error("speed reply with linear product");
`endif

endmodule

`default_nettype wire

FILE: rtl/laser_sector_obstacle_steering.sv
// ----------------------------------------------------------------------------
// laser_sector_obstacle_steering
// A request passes the input register, the stage 1 register and command stages 2 and 3.
// Throughput: one request per cycle while the result side does not stall the pipeline.
// Reset clears counters, running minimum, speed (1.0) and config registers;
// the five sector minima are not reset and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module laser_sector_obstacle_steering #(
  parameter int MAX_SECTOR_SAMPLES = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsos_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lsos_pkg::CfgDataW-1:0]  cfg_wdata_i,
  lsos_in_if.sink                        sample_i,
  lsos_out_if.source                     result_o
);
  import lsos_pkg::*;

  localparam int CntW  = $clog2(MAX_SECTOR_SAMPLES + 1);
  localparam int SizeW = (CntW > SpsW) ? CntW : SpsW;
  localparam logic [SizeW-1:0] MaxSize = SizeW'(MAX_SECTOR_SAMPLES);

  // configuration registers
  logic [SpsW-1:0]    sps_q;
  logic [15:0]        stop_q;
  logic [15:0]        tdist_q;
  logic [15:0]        gain_q;
  logic signed [15:0] idle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_q   <= SPS_RESET;
      stop_q  <= STOP_RESET;
      tdist_q <= TURN_DIST_RESET;
      gain_q  <= TURN_GAIN_RESET;
      idle_q  <= IDLE_TURN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SAMPLES_PER_SECTOR: sps_q   <= cfg_wdata_i[SpsW-1:0];
        CFG_STOP_DISTANCE:      stop_q  <= cfg_wdata_i;
        CFG_TURN_DISTANCE:      tdist_q <= cfg_wdata_i;
        CFG_TURN_GAIN:          gain_q  <= cfg_wdata_i;
        CFG_IDLE_TURN:          idle_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stall chain
  logic ready0, ready1, cmd_ready;
  logic vld0_q, vld1_q;
  logic adv0;

  assign ready1         = !vld1_q || cmd_ready;
  assign ready0         = !vld0_q || ready1;
  assign adv0           = vld0_q && ready1;
  assign sample_i.ready = ready0;

  // input register
  logic               func0_q;
  logic [15:0]        range0_q;
  logic signed [15:0] delta0_q;
  logic               last0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (ready0) begin
      vld0_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready0 && sample_i.valid) begin
      func0_q  <= sample_i.func;
      range0_q <= sample_i.range_value;
      delta0_q <= sample_i.speed_step;
      last0_q  <= sample_i.last_of_scan;
    end
  end

  // scan state
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      idx_q, idx_d;
  logic [15:0]     rmin_q, rmin_d;
  logic [15:0]     speed_q, speed_d;
  logic [15:0]     sec_min_q [NUM_SECTORS];

  logic [SizeW-1:0]   sps_ext;
  logic [SizeW-1:0]   size_w;
  logic [CntW-1:0]    cnt_inc;
  logic               sector_done;
  logic [15:0]        new_min;
  logic signed [17:0] spd_sum;
  logic [15:0]        spd_clamped;
  logic               sec_we;
  logic               produce;
  cmd_req_t           req1_d, req1_q;

  // sector size, zero taken as one and capped at the maximum
  always_comb begin
    sps_ext = SizeW'(sps_q);
    if (sps_q == '0) begin
      size_w = SizeW'(1);
    end else if (sps_ext > MaxSize) begin
      size_w = MaxSize;
    end else begin
      size_w = sps_ext;
    end
  end

  // per-sample arithmetic
  always_comb begin
    cnt_inc     = cnt_q + 1'b1;
    sector_done = SizeW'(cnt_inc) >= size_w;
    new_min     = (range0_q < rmin_q) ? range0_q : rmin_q;
    spd_sum     = $signed({2'b00, speed_q}) + $signed({{2{delta0_q[15]}}, delta0_q});
    if (spd_sum < 18'sd0) begin
      spd_clamped = 16'd0;
    end else if (spd_sum[16]) begin
      spd_clamped = 16'hFFFF;
    end else begin
      spd_clamped = spd_sum[15:0];
    end
  end

  // state update for the request leaving the input register
  always_comb begin
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    rmin_d  = rmin_q;
    speed_d = speed_q;
    sec_we  = 1'b0;
    produce = 1'b0;

    req1_d.kind       = KIND_DRIVE;
    req1_d.speed      = speed_q;
    req1_d.min_right  = sec_min_q[SEC_RIGHT];
    req1_d.min_fright = sec_min_q[SEC_FRIGHT];
    req1_d.min_front  = sec_min_q[SEC_FRONT];
    req1_d.min_fleft  = sec_min_q[SEC_FLEFT];
    req1_d.min_left   = new_min;

    if (adv0) begin
      if (func0_q == FUNC_SPEED) begin
        speed_d      = spd_clamped;
        produce      = 1'b1;
        req1_d.kind  = KIND_SPEED;
        req1_d.speed = spd_clamped;
      end else begin
        if (idx_q < NUM_SECTORS) begin
          rmin_d = new_min;
          cnt_d  = cnt_inc;
          if (sector_done) begin
            sec_we = 1'b1;
            rmin_d = RANGE_MAX;
            cnt_d  = '0;
            idx_d  = idx_q + 3'd1;
            if (idx_q == SEC_LEFT && speed_q != 16'd0) begin
              produce = 1'b1;
            end
          end
        end
        if (last0_q) begin
          cnt_d  = '0;
          idx_d  = '0;
          rmin_d = RANGE_MAX;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      idx_q   <= '0;
      rmin_q  <= RANGE_MAX;
      speed_q <= SPEED_RESET;
    end else begin
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      rmin_q  <= rmin_d;
      speed_q <= speed_d;
    end
  end

  // sector minima
  always_ff @(posedge clk_i) begin
    if (sec_we) begin
      sec_min_q[idx_q] <= new_min;
    end
  end

  // stage 1 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (ready1) begin
      vld1_q <= produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && produce) begin
      req1_q <= req1_d;
    end
  end

  // command datapath and result register
  cmd_rsp_t rsp;

  lsos_cmd u_cmd (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stop_distance_i (stop_q),
    .turn_distance_i (tdist_q),
    .turn_gain_i     (gain_q),
    .idle_turn_i     (idle_q),
    .req_valid_i     (vld1_q),
    .req_ready_o     (cmd_ready),
    .req_i           (req1_q),
    .rsp_valid_o     (result_o.valid),
    .rsp_ready_i     (result_o.ready),
    .rsp_o           (rsp)
  );

  assign result_o.kind        = rsp.kind;
  assign result_o.linear_cmd  = rsp.linear;
  assign result_o.angular_cmd = rsp.angular;
  assign result_o.speed_now   = rsp.speed;

`ifndef SYNTHESIS
  // sector index never runs beyond one past the last sector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= NUM_SECTORS)
    else $error("sector index out of range");

  // once all sectors are done, leftover samples leave the counter untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q == NUM_SECTORS) |-> (cnt_q == '0 && rmin_q == RANGE_MAX))
    else $error("leftover samples changed sector state");

  // a sector minimum is written only while a sector is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_we |-> (idx_q < NUM_SECTORS && adv0 && func0_q == FUNC_SAMPLE))
    else $error("sector minimum written outside a sector");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_laser_sector_obstacle_steering.sv
// ----------------------------------------------------------------------------
// tb_laser_sector_obstacle_steering
// Drives laser range and speed change requests into the steering block and
// checks every drive command and speed reply against a cycle-free predictor.
// Configuration changes only between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_laser_sector_obstacle_steering;
  import lsos_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 8;
  localparam int QUIET_LIMIT    = 1000;
  localparam int MAX_WAIT       = 13;
  localparam int RANDOM_ITEMS   = 450;
  localparam int PHASE_ITEMS    = 50;
  localparam int MAX_SECTOR_LEN = 256;
  localparam int SHOWN_ERRORS   = 10;

  typedef enum int {SCAN_FULL, SCAN_LEFTOVER, SCAN_SHORT, SCAN_NOISE} scan_shape_e;

  typedef struct packed {
    logic               func;
    logic [15:0]        range_value;
    logic signed [15:0] speed_step;
    logic               last_of_scan;
  } sample_req_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  lsos_in_if  sample_if ();
  lsos_out_if result_if ();

  laser_sector_obstacle_steering u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_if),
    .result_o    (result_if)
  );

  // requests waiting to be sent and commands waiting to come back
  sample_req_t pending_reqs[$];
  cmd_rsp_t    expected_cmds[$];

  // predictor copy of the configuration registers
  logic [8:0]         sps_reg;
  logic [15:0]        stop_reg;
  logic [15:0]        turn_reg;
  logic [15:0]        gain_reg;
  logic signed [15:0] idle_reg;

  // predictor copy of the scan and speed state
  int          seen_in_sector;
  int          sector_at;
  logic [15:0] scan_min;
  logic [15:0] sector_min [5];
  logic [15:0] speed_q;

  int          idle_max;
  int          pushed_items;
  int          mismatches;
  int          quiet_cycles;
  int          send_wait;
  int          recv_wait;
  int          gap;
  int          stall;
  sample_req_t send_req;
  cmd_rsp_t    next_cmd;
  cmd_rsp_t    want;
  bit          got_cmd;

  always #HALF_PERIOD clk_i = ~clk_i;

  // effective sector length after the zero and oversize rules
  function automatic int sector_len(logic [8:0] sps);
    if (sps == 0) return 1;
    if (sps > MAX_SECTOR_LEN) return MAX_SECTOR_LEN;
    return int'(sps);
  endfunction

  // turning weight of one side sector
  function automatic longint side_pull(logic [15:0] side_range);
    if (side_range >= turn_reg) return 0;
    return ((longint'(turn_reg) - longint'(side_range)) * longint'(gain_reg)) >>> 8;
  endfunction

  // advance the predicted state by one request, returns 1 when a result is due
  function automatic bit predict_step(input sample_req_t req, output cmd_rsp_t cmd);
    longint      next_speed;
    longint      diff;
    longint      angle;
    logic [15:0] front;
    bit          made;
    made = 1'b0;
    cmd  = '0;
    if (req.func == FUNC_SPEED) begin
      next_speed = longint'(speed_q) + longint'($signed(req.speed_step));
      if (next_speed < 0) next_speed = 0;
      if (next_speed > 65535) next_speed = 65535;
      speed_q   = 16'(next_speed);
      cmd.kind  = KIND_SPEED;
      cmd.speed = speed_q;
      return 1'b1;
    end
    if (sector_at < NUM_SECTORS) begin
      if (req.range_value < scan_min) scan_min = req.range_value;
      seen_in_sector++;
      if (seen_in_sector >= sector_len(sps_reg)) begin
        sector_min[sector_at] = scan_min;
        scan_min       = RANGE_MAX;
        seen_in_sector = 0;
        sector_at++;
        if (sector_at == NUM_SECTORS && speed_q != 0) begin
          front = sector_min[SEC_FRONT];
          diff  = (front > stop_reg) ? longint'(front) - longint'(stop_reg) : 0;
          if (diff > longint'(Q_ONE)) diff = longint'(Q_ONE);
          angle = side_pull(sector_min[SEC_RIGHT]) + side_pull(sector_min[SEC_FRIGHT])
                - side_pull(sector_min[SEC_FLEFT]) - side_pull(sector_min[SEC_LEFT]);
          if (angle > 32767) angle = 32767;
          if (angle < -32768) angle = -32768;
          cmd.kind    = KIND_DRIVE;
          cmd.linear  = 16'((diff * longint'(speed_q)) >>> 8);
          cmd.angular = (cmd.linear == 0 && angle == 0) ? idle_reg : 16'(angle);
          cmd.speed   = speed_q;
          made = 1'b1;
        end
      end
    end
    // end of scan returns the counters to their reset state
    if (req.last_of_scan) begin
      seen_in_sector = 0;
      sector_at      = 0;
      scan_min       = RANGE_MAX;
    end
    return made;
  endfunction

  function automatic int draw_wait();
    return (idle_max == 0) ? 0 : int'($urandom_range(0, idle_max));
  endfunction

  function automatic void push_sample(logic [15:0] range_in, logic last);
    pending_reqs.push_back('{func: FUNC_SAMPLE, range_value: range_in,
                             speed_step: 16'($urandom), last_of_scan: last});
    pushed_items++;
  endfunction

  function automatic void push_speed(logic [15:0] delta, logic last);
    pending_reqs.push_back('{func: FUNC_SPEED, range_value: 16'($urandom),
                             speed_step: delta, last_of_scan: last});
    pushed_items++;
  endfunction

  // range values clustered around the thresholds that matter
  function automatic logic [15:0] pick_range();
    int v;
    case ($urandom_range(0, 5))
      0: v = int'($urandom_range(0, 65535));
      1: v = int'(stop_reg) + int'($urandom_range(0, 600)) - 300;
      2: v = int'(turn_reg) + int'($urandom_range(0, 600)) - 300;
      3: v = int'($urandom_range(0, 1023));
      4: v = 65535;
      default: v = int'($urandom_range(0, 2047));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic logic [15:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'h8000;
      2: return 16'h7FFF;
      default: return 16'(int'($urandom_range(0, 500)) - 200);
    endcase
  endfunction

  // one scan of the given shape, always closed by last_of_scan
  function automatic void push_scan(scan_shape_e shape);
    int n;
    int len;
    n = int'(NUM_SECTORS) * sector_len(sps_reg);
    case (shape)
      SCAN_FULL:     len = n;
      SCAN_LEFTOVER: len = n + int'($urandom_range(1, 3));
      SCAN_SHORT:    len = int'($urandom_range(1, n - 1));
      default:       len = int'($urandom_range(1, 4));
    endcase
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) push_speed(pick_delta(), 1'($urandom_range(0, 1)));
      push_sample(pick_range(),
                  (i == len - 1) || (shape == SCAN_NOISE && $urandom_range(0, 2) == 0));
    end
  endfunction

  // wait until nothing is in flight, then let the pipeline settle
  task automatic drain();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || sample_if.valid || expected_cmds.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_regs(logic [8:0] sps, logic [15:0] stop, logic [15:0] turn,
                              logic [15:0] gain, logic signed [15:0] idle);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SAMPLES_PER_SECTOR;
    cfg_wdata_i <= 16'(sps);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_STOP_DISTANCE;
    cfg_wdata_i <= stop;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TURN_DISTANCE;
    cfg_wdata_i <= turn;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TURN_GAIN;
    cfg_wdata_i <= gain;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_IDLE_TURN;
    cfg_wdata_i <= idle;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sps_reg  = sps;
    stop_reg = stop;
    turn_reg = turn;
    gain_reg = gain;
    idle_reg = idle;
    @(negedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_if.valid        <= 1'b0;
      sample_if.func         <= FUNC_SAMPLE;
      sample_if.range_value  <= '0;
      sample_if.speed_step   <= '0;
      sample_if.last_of_scan <= 1'b0;
      send_wait              <= 0;
    end else if (!sample_if.valid || sample_if.ready) begin
      gap = sample_if.valid ? draw_wait() : send_wait;
      if (gap != 0) begin
        sample_if.valid <= 1'b0;
        send_wait       <= gap - 1;
      end else if (pending_reqs.size() != 0) begin
        send_req = pending_reqs.pop_front();
        sample_if.func         <= send_req.func;
        sample_if.range_value  <= send_req.range_value;
        sample_if.speed_step   <= send_req.speed_step;
        sample_if.last_of_scan <= send_req.last_of_scan;
        sample_if.valid        <= 1'b1;
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      recv_wait       <= 0;
    end else begin
      stall = (result_if.valid && result_if.ready) ? draw_wait() : recv_wait;
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        recv_wait       <= stall - 1;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      seen_in_sector = 0;
      sector_at      = 0;
      scan_min       = RANGE_MAX;
      speed_q        = SPEED_RESET;
      foreach (sector_min[i]) sector_min[i] = '0;
    end else begin
      got_cmd = 1'b0;
      if (sample_if.valid && sample_if.ready) begin
        got_cmd = predict_step('{func: sample_if.func, range_value: sample_if.range_value,
                                 speed_step: sample_if.speed_step,
                                 last_of_scan: sample_if.last_of_scan}, next_cmd);
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("unexpected result: kind %0d linear %0d angular %0d speed %0d",
                     result_if.kind, result_if.linear_cmd, $signed(result_if.angular_cmd),
                     result_if.speed_now);
        end else begin
          want = expected_cmds.pop_front();
          if (want.kind !== result_if.kind || want.linear !== result_if.linear_cmd ||
              want.angular !== result_if.angular_cmd || want.speed !== result_if.speed_now)
          begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
              $display("mismatch exp/act: kind %0d/%0d linear %0d/%0d angular %0d/%0d %s",
                       want.kind, result_if.kind, want.linear, result_if.linear_cmd,
                       $signed(want.angular), $signed(result_if.angular_cmd),
                       $sformatf("speed %0d/%0d", want.speed, result_if.speed_now));
          end
        end
      end
      if (got_cmd) expected_cmds.push_back(next_cmd);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
          cfg_we_i)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    int          phase;
    int          start;
    int          r;
    scan_shape_e shape;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_SAMPLES_PER_SECTOR;
    cfg_wdata_i  = '0;
    idle_max     = MAX_WAIT;
    pushed_items = 0;
    sps_reg      = SPS_RESET;
    stop_reg     = STOP_RESET;
    turn_reg     = TURN_DIST_RESET;
    gain_reg     = TURN_GAIN_RESET;
    idle_reg     = IDLE_TURN_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // reset configuration: speed reply with ignored end flag, short scan dropped
    push_speed(16'h0000, 1'b1);
    push_sample(16'h1234, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    drain();

    // one sample per sector, sector size zero taken as one
    program_regs(9'd0, 16'd256, 16'd512, 16'd512, 16'sh8000);
    // open scan at full range gives full linear speed
    for (int i = 0; i < 5; i++) push_sample(16'hFFFF, i == 4);
    // walls everywhere: balanced sides fall back to the idle turn, then leftovers
    for (int i = 0; i < 7; i++) push_sample(16'h0000, i == 6);
    // zero speed suppresses the command, then the speed saturates upward
    push_speed(16'h8000, 1'b0);
    for (int i = 0; i < 5; i++) push_sample(16'h0300, i == 4);
    push_speed(16'h7FFF, 1'b0);
    push_speed(16'h7FFF, 1'b0);
    push_speed(16'h7FFF, 1'b0);

    // random phases, each with its own configuration and idling
    phase = 0;
    while (pushed_items < RANDOM_ITEMS) begin
      drain();
      if (phase == 3 || phase == 4) begin
        // largest sector sizes, oversize value saturating; scans end early
        program_regs((phase == 3) ? 9'd511 : 9'd256, 16'($urandom_range(0, 1024)),
                     16'($urandom_range(0, 2047)), 16'($urandom_range(0, 1023)),
                     16'($urandom));
        idle_max = 0;
        push_scan(SCAN_NOISE);
      end else begin
        if (phase == 0) begin
          program_regs(9'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'sh7FFF);
          idle_max = MAX_WAIT;
        end else if (phase == 1) begin
          program_regs(9'd2, 16'hFFFF, 16'd0, 16'd0, 16'sh8000);
          idle_max = 0;
        end else begin
          program_regs(9'($urandom_range(0, 4)),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024)),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047)),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023)),
                       16'($urandom));
          idle_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
        end
        start = pushed_items;
        while (pushed_items - start < PHASE_ITEMS) begin
          r = int'($urandom_range(0, 9));
          if (r < 6) shape = SCAN_FULL;
          else if (r == 6) shape = SCAN_LEFTOVER;
          else if (r < 9) shape = SCAN_SHORT;
          else shape = SCAN_NOISE;
          push_scan(shape);
        end
      end
      phase++;
    end

    drain();
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
